FILE: sv/mpeg_audio_frame_length_top_assert.svh
// Assertion macros for the frame length block.
`ifndef MPEG_AUDIO_FRAME_LENGTH_TOP_ASSERT_SVH
`define MPEG_AUDIO_FRAME_LENGTH_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MAFL_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MAFL_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mafl_pkg.sv
`timescale 1ns / 1ps

package mafl_pkg;

  localparam int QW = 12;          // quotient bits, one per divider cell
  localparam int NW = 26;          // numerator width
  localparam int FW = 16;          // sample rate width
  localparam int DW = FW + QW - 1; // divisor / remainder width in the cells
  localparam int BW = 8;           // byte rate width
  localparam int KW = 21;          // samples * 1000
  localparam int LW = 12;          // frame length width

  localparam logic [2:0] TYPE_V1_L1  = 3'd0;
  localparam logic [2:0] TYPE_V1_L2  = 3'd1;
  localparam logic [2:0] TYPE_V1_L3  = 3'd2;
  localparam logic [2:0] TYPE_V2_L1  = 3'd3;
  localparam logic [2:0] TYPE_V2_L2  = 3'd4;
  localparam logic [2:0] TYPE_V2_L3  = 3'd5;
  localparam logic [2:0] TYPE_NONE   = 3'd6;

  localparam logic [10:0]   SYNC_PATTERN = 11'h7ff;
  localparam logic [BW-1:0] RATE_BAD     = 8'hff;

  // Data handed from cell to cell.
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] dvs;
    logic [QW-1:0] quo;
    logic          ok;
    logic          l1;
    logic          pad;
  } div_t;

  // {version, layer} to frame type
  function automatic logic [2:0] type_of(input logic [3:0] vl);
    logic [2:0] t;
    case (vl)
      4'd1, 4'd9:  t = TYPE_V2_L3;
      4'd2, 4'd10: t = TYPE_V2_L2;
      4'd3, 4'd11: t = TYPE_V2_L1;
      4'd13:       t = TYPE_V1_L3;
      4'd14:       t = TYPE_V1_L2;
      4'd15:       t = TYPE_V1_L1;
      default:     t = TYPE_NONE;
    endcase
    return t;
  endfunction

  localparam logic [BW-1:0] RATE_TAB [6][16] = '{
    '{8'd0, 8'd4, 8'd8, 8'd12, 8'd16, 8'd20, 8'd24, 8'd28,
      8'd32, 8'd36, 8'd40, 8'd44, 8'd48, 8'd52, 8'd56, 8'd255},
    '{8'd0, 8'd4, 8'd6, 8'd7, 8'd8, 8'd10, 8'd12, 8'd14,
      8'd16, 8'd20, 8'd24, 8'd28, 8'd32, 8'd40, 8'd48, 8'd255},
    '{8'd0, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd10, 8'd12,
      8'd14, 8'd16, 8'd20, 8'd24, 8'd28, 8'd32, 8'd40, 8'd255},
    '{8'd0, 8'd4, 8'd6, 8'd7, 8'd8, 8'd10, 8'd12, 8'd14,
      8'd16, 8'd18, 8'd20, 8'd22, 8'd24, 8'd28, 8'd32, 8'd255},
    '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7,
      8'd8, 8'd10, 8'd12, 8'd14, 8'd16, 8'd18, 8'd20, 8'd255},
    '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7,
      8'd8, 8'd10, 8'd12, 8'd14, 8'd16, 8'd18, 8'd20, 8'd255}
  };

  function automatic logic [BW-1:0] rate_of(input logic [2:0] t, input logic [3:0] bri);
    logic [BW-1:0] r;
    if (t >= TYPE_NONE) begin
      r = '0;
    end else begin
      r = RATE_TAB[t][bri];
    end
    return r;
  endfunction

  localparam logic [FW-1:0] FREQ_TAB [4][4] = '{
    '{16'd11025, 16'd12000, 16'd8000,  16'd0},
    '{16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd22050, 16'd24000, 16'd16000, 16'd0},
    '{16'd44100, 16'd48000, 16'd32000, 16'd0}
  };

  function automatic logic [FW-1:0] freq_of(input logic [1:0] ver, input logic [1:0] sri);
    return FREQ_TAB[ver][sri];
  endfunction

  // Samples per frame times 1000; layer I counted in 4-byte slots.
  function automatic logic [KW-1:0] kilo_samples(input logic [2:0] t);
    logic [KW-1:0] k;
    case (t)
      TYPE_V1_L1, TYPE_V2_L1: k = KW'(96000);
      TYPE_V1_L2, TYPE_V1_L3, TYPE_V2_L2: k = KW'(1152000);
      TYPE_V2_L3: k = KW'(576000);
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

FILE: sv/mafl_if.sv
`timescale 1ns / 1ps

interface mafl_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;

  modport source (output valid, output header_word, input ready);
  modport sink (input valid, input header_word, output ready);
endinterface

interface mafl_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] frame_bytes;
  logic        frame_ok;

  modport source (output valid, output frame_bytes, output frame_ok, input ready);
  modport sink (input valid, input frame_bytes, input frame_ok, output ready);
endinterface

FILE: sv/mpeg_audio_frame_length_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                         Handshake
// in_chan   in   header_word[31:0]               valid/ready
// out_chan  out  frame_bytes[11:0], frame_ok     valid/ready
//
// One header per cycle sustained while out_chan does not stall; the pipeline is one
// decode/multiply stage, twelve divider cells (one quotient bit each), one output register.
// The divider row holds up to twelve headers in flight.
// Reset (rst_n, synchronous) empties every stage; no payload is cleared.
// Each stage loads when it is empty or its successor moves, so bubbles close
// up under an output stall, and in_chan stays ready until every stage is full.

module mpeg_audio_frame_length_top import mafl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mafl_in_if.sink    in_chan,
  mafl_out_if.source out_chan
);

  // Stage 0 is the decoder, stages 1..QW the divider cells.
  logic [QW:0] vld;
  logic [QW:0] adv;
  div_t        dat [0:QW];

  logic          out_valid_r;
  logic [LW-1:0] bytes_r;
  logic          ok_r;
  logic          out_adv;

  logic [LW-1:0] base_len;
  logic [LW-1:0] slot_len;
  logic [LW-1:0] len;

  // Ready ripples back from the output register through the row.
  assign out_adv = !out_valid_r || out_chan.ready;
  assign adv[QW] = !vld[QW] || out_adv;

  genvar gi;
  generate
    for (gi = 0; gi < QW; gi++) begin : g_adv
      assign adv[gi] = !vld[gi] || adv[gi+1];
    end
  endgenerate

  assign in_chan.ready = adv[0];

  mafl_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_chan.valid),
    .header_word(in_chan.header_word),
    .take       (adv[0]),
    .valid_r    (vld[0]),
    .data_r     (dat[0])
  );

  // Divider row: cell k resolves quotient bit QW-k.
  generate
    for (gi = 1; gi <= QW; gi++) begin : g_cell
      mafl_div_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .up_valid(vld[gi-1]),
        .up_data (dat[gi-1]),
        .take    (adv[gi]),
        .valid_r (vld[gi]),
        .data_r  (dat[gi])
      );
    end
  endgenerate

  // Layer I: quotient is a slot count, scale by 4 bytes; padding adds a slot.
  always_comb begin
    base_len = dat[QW].l1 ? {dat[QW].quo[QW-3:0], 2'b00} : LW'(dat[QW].quo);
    slot_len = dat[QW].l1 ? LW'(4) : LW'(1);
    len      = dat[QW].ok ? (base_len + (dat[QW].pad ? slot_len : '0)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      bytes_r <= len;
      ok_r    <= len != '0;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.frame_bytes = bytes_r;
  assign out_chan.frame_ok    = ok_r;

`include "mpeg_audio_frame_length_top_assert.svh"

  // Input only stalls once every stage and the output register hold a transaction.
  `MAFL_CHECK(a_full_when_stalled, !in_chan.ready, (&vld) && out_valid_r, "input stalled with a free stage")
  // A header with a bad sync pattern must be marked invalid at decode.
  `MAFL_CHECK_NEXT(a_bad_sync, in_chan.valid && in_chan.ready && (in_chan.header_word[31:21] != SYNC_PATTERN), !dat[0].ok, "bad sync decoded as valid")
  // A valid output reports ok exactly when the length is nonzero.
  `MAFL_CHECK(a_ok_match, out_valid_r, ok_r == (bytes_r != '0), "frame_ok disagrees with frame_bytes")

endmodule

FILE: sv/mafl_decode.sv
`timescale 1ns / 1ps

module mafl_decode import mafl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  input  logic [31:0] header_word,
  input  logic        take,
  output logic        valid_r,
  output div_t        data_r
);

  logic [2:0]       ftype;
  logic [BW-1:0]    brate;
  logic [FW-1:0]    freq;
  logic             ok;
  logic [KW+BW-1:0] prod;
  div_t             data_nxt;

  always_comb begin
    ftype = type_of(header_word[20:17]);
    brate = rate_of(ftype, header_word[15:12]);
    freq  = freq_of(header_word[20:19], header_word[11:10]);
    ok    = (header_word[31:21] == SYNC_PATTERN) && (ftype != TYPE_NONE) &&
            (brate != '0) && (brate != RATE_BAD) && (freq != '0);
    prod  = kilo_samples(ftype) * brate;

    data_nxt.rem = ok ? DW'(prod[NW-1:0]) : '0;
    data_nxt.dvs = {freq, {(QW-1){1'b0}}};
    data_nxt.quo = '0;
    data_nxt.ok  = ok;
    data_nxt.l1  = (ftype == TYPE_V1_L1) || (ftype == TYPE_V2_L1);
    data_nxt.pad = header_word[9];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: sv/mafl_div_cell.sv
`timescale 1ns / 1ps

// One restoring-division step: trial subtract, shift in a quotient bit,
// halve the divisor for the next cell.
module mafl_div_cell import mafl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  input  div_t up_data,
  input  logic take,
  output logic valid_r,
  output div_t data_r
);

  logic fits;
  div_t data_nxt;

  always_comb begin
    fits         = up_data.rem >= up_data.dvs;
    data_nxt     = up_data;
    data_nxt.rem = fits ? (up_data.rem - up_data.dvs) : up_data.rem;
    data_nxt.dvs = up_data.dvs >> 1;
    data_nxt.quo = {up_data.quo[QW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: test/mpeg_audio_frame_length_top_test.sv
`timescale 1ns / 1ps

module mpeg_audio_frame_length_top_test;

  // Header field codes, as they appear in bits 20..17, 15..12 and 11..10.
  localparam logic [1:0] VER_25   = 2'b00;
  localparam logic [1:0] VER_RSVD = 2'b01;
  localparam logic [1:0] VER_2    = 2'b10;
  localparam logic [1:0] VER_1    = 2'b11;

  localparam logic [1:0] LAYER_RSVD = 2'b00;
  localparam logic [1:0] LAYER_3    = 2'b01;
  localparam logic [1:0] LAYER_2    = 2'b10;
  localparam logic [1:0] LAYER_1    = 2'b11;

  localparam logic [3:0] BRI_FREE = 4'd0;
  localparam logic [3:0] BRI_BAD  = 4'd15;
  localparam logic [1:0] SRI_RSVD = 2'd3;

  localparam logic [10:0] SYNC_WORD      = 11'h7ff;
  localparam int unsigned RATE_FORBIDDEN = 255;

  localparam int PHASE_ITEMS = 237;  // random headers per idling pattern
  localparam int TAIL_CYCLES = 16;   // pipeline depth plus margin

  typedef enum logic [2:0] {
    KIND_V1_L1, KIND_V1_L2, KIND_V1_L3,
    KIND_V2_L1, KIND_V2_L2, KIND_V2_L3,
    KIND_NONE
  } frame_kind_e;

  // Byte rate (kbit/s / 8) per frame kind and bitrate index.
  localparam int unsigned BYTE_RATE [6][16] = '{
    '{0, 4, 8, 12, 16, 20, 24, 28, 32, 36, 40, 44, 48, 52, 56, 255},
    '{0, 4, 6, 7, 8, 10, 12, 14, 16, 20, 24, 28, 32, 40, 48, 255},
    '{0, 4, 5, 6, 7, 8, 10, 12, 14, 16, 20, 24, 28, 32, 40, 255},
    '{0, 4, 6, 7, 8, 10, 12, 14, 16, 18, 20, 22, 24, 28, 32, 255},
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 10, 12, 14, 16, 18, 20, 255},
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 10, 12, 14, 16, 18, 20, 255}
  };

  // Sample rate in Hz per version code and rate index; 0 marks reserved.
  localparam int unsigned SAMPLE_RATE [4][4] = '{
    '{11025, 12000, 8000, 0},
    '{0, 0, 0, 0},
    '{22050, 24000, 16000, 0},
    '{44100, 48000, 32000, 0}
  };

  typedef struct {
    logic [31:0] hdr;
    logic [11:0] frame_bytes;
    logic        frame_ok;
  } frame_len_t;

  logic clk = 1'b0;
  logic rst_n;

  mafl_in_if  in_chan ();
  mafl_out_if out_chan ();

  mpeg_audio_frame_length_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Expected lengths, oldest first; one entry per accepted header.
  frame_len_t pending_lengths[$];

  int idle_pct = 0;   // chance that the sender idles before a header
  int stall_pct = 0;  // chance per falling edge that the receiver holds off

  int error_count = 0;
  int header_count = 0;
  int result_count = 0;
  int good_frame_count = 0;

  // 12 ns period clock; starts low so the first event is a rising edge.
  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  // Frame length of one header word, computed from the header fields.
  // Layer I counts whole 4-byte slots, so its quotient is truncated
  // before scaling back to bytes.
  function automatic frame_len_t calc_frame_length(input logic [31:0] hdr);
    frame_len_t  r;
    frame_kind_e kind;
    int unsigned rate;
    int unsigned freq;
    int unsigned len;
    r.hdr = hdr;
    len = 0;
    case ({hdr[20:19], hdr[18:17]})
      {VER_1, LAYER_1}:                     kind = KIND_V1_L1;
      {VER_1, LAYER_2}:                     kind = KIND_V1_L2;
      {VER_1, LAYER_3}:                     kind = KIND_V1_L3;
      {VER_2, LAYER_1}, {VER_25, LAYER_1}: kind = KIND_V2_L1;
      {VER_2, LAYER_2}, {VER_25, LAYER_2}: kind = KIND_V2_L2;
      {VER_2, LAYER_3}, {VER_25, LAYER_3}: kind = KIND_V2_L3;
      default:                              kind = KIND_NONE;
    endcase
    if (hdr[31:21] == SYNC_WORD && kind != KIND_NONE) begin
      rate = BYTE_RATE[int'(kind)][hdr[15:12]];
      freq = SAMPLE_RATE[hdr[20:19]][hdr[11:10]];
      if (rate != 0 && rate != RATE_FORBIDDEN && freq != 0) begin
        case (kind)
          KIND_V1_L1, KIND_V2_L1: len = (96 * rate * 1000 / freq) * 4 + (hdr[9] ? 4 : 0);
          KIND_V2_L3:             len = 576 * rate * 1000 / freq + hdr[9];
          default:                len = 1152 * rate * 1000 / freq + hdr[9];
        endcase
      end
    end
    r.frame_bytes = len[11:0];
    r.frame_ok = (len != 0);
    return r;
  endfunction

  function automatic logic [31:0] make_header(input logic [1:0] ver, input logic [1:0] lay,
                                              input logic [3:0] bri, input logic [1:0] sri,
                                              input logic pad);
    return {SYNC_WORD, ver, lay, 1'b1, bri, sri, pad, 9'h000};
  endfunction

  // Mostly well-formed headers with random content; the rest carry a
  // broken sync or are fully random words.
  function automatic logic [31:0] random_header();
    logic [31:0] hdr;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [3:0]  bri;
    logic [1:0]  sri;
    int          roll;
    roll = $urandom_range(99);
    case ($urandom_range(2))
      0:       ver = VER_1;
      1:       ver = VER_2;
      default: ver = VER_25;
    endcase
    if ($urandom_range(19) == 0) ver = VER_RSVD;
    lay = ($urandom_range(19) == 0) ? LAYER_RSVD : 2'($urandom_range(3, 1));
    bri = ($urandom_range(14) == 0) ? ($urandom_range(1) ? BRI_BAD : BRI_FREE)
                                    : 4'($urandom_range(14, 1));
    sri = ($urandom_range(14) == 0) ? SRI_RSVD : 2'($urandom_range(2));
    hdr = {SYNC_WORD, ver, lay, 1'($urandom), bri, sri, 1'($urandom), 9'($urandom)};
    if (roll >= 95) begin
      hdr = $urandom;
    end else if (roll >= 88) begin
      hdr[21 + $urandom_range(10)] = 1'b0;  // one sync bit knocked out
    end
    return hdr;
  endfunction

  // Offer one header at a falling edge, with a random gap first, and hold
  // it until the transaction completes. Returns on the next falling edge.
  task automatic send_header(input logic [31:0] hdr);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.header_word <= hdr;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Sender goes quiet until every expected length has come back.
  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    while (pending_lengths.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_header(random_header());
    wait_for_drain();
  endtask

  // Each rejection case, every version/layer pair, and the length extremes.
  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_header(32'h0000_0000);                                        // no sync at all
    send_header(make_header(VER_1, LAYER_2, 4'd9, 2'd0, 1'b0) & ~32'h0020_0000);
    send_header(make_header(VER_RSVD, LAYER_2, 4'd9, 2'd0, 1'b0));     // reserved version
    send_header(make_header(VER_1, LAYER_RSVD, 4'd9, 2'd0, 1'b0));     // reserved layer
    send_header(make_header(VER_1, LAYER_3, BRI_BAD, 2'd0, 1'b1));     // forbidden bitrate
    send_header(make_header(VER_1, LAYER_3, 4'd9, SRI_RSVD, 1'b0));    // reserved rate
    send_header(make_header(VER_2, LAYER_2, BRI_FREE, 2'd1, 1'b1));    // free format
    send_header(32'hffff_ffff);                                        // layer I, bitrate 15
    send_header(make_header(VER_1, LAYER_1, 4'd1, 2'd0, 1'b0));        // layer I truncation
    send_header(make_header(VER_1, LAYER_1, 4'd14, 2'd2, 1'b1));
    send_header(make_header(VER_1, LAYER_2, 4'd14, 2'd2, 1'b0));
    send_header(make_header(VER_1, LAYER_3, 4'd9, 2'd0, 1'b1));        // 128k at 44.1k
    send_header(make_header(VER_2, LAYER_1, 4'd7, 2'd1, 1'b1));
    send_header(make_header(VER_2, LAYER_2, 4'd5, 2'd0, 1'b0));
    send_header(make_header(VER_2, LAYER_3, 4'd1, 2'd1, 1'b0));        // shortest frame
    send_header(make_header(VER_25, LAYER_1, 4'd14, 2'd2, 1'b1));
    send_header(make_header(VER_25, LAYER_2, 4'd14, 2'd2, 1'b1));      // longest frame
    send_header(make_header(VER_25, LAYER_3, 4'd3, 2'd0, 1'b1));
    send_header(make_header(VER_1, LAYER_3, 4'd9, 2'd0, 1'b1) | 32'h0001_01ff); // ignored bits
    send_header(make_header(VER_2, LAYER_3, 4'd14, 2'd2, 1'b1));
    wait_for_drain();
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    stall_pct = 0;
    run_random(PHASE_ITEMS);
  endtask

  task automatic test_sender_gaps();
    idle_pct = 61;
    stall_pct = 0;
    run_random(PHASE_ITEMS);
  endtask

  task automatic test_receiver_stalls();
    idle_pct = 0;
    stall_pct = 61;
    run_random(PHASE_ITEMS);
  endtask

  task automatic test_both_idle();
    idle_pct = 21;
    stall_pct = 21;
    run_random(PHASE_ITEMS);
  endtask

  // Receiver back-pressure, redrawn every falling edge.
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Scoreboard: check the result transaction first, then queue the
  // prediction for any header accepted on the same edge.
  always @(posedge clk) begin
    frame_len_t want;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        result_count++;
        if (pending_lengths.size() == 0) begin
          $display("%0t: unexpected result: frame_bytes %0d frame_ok %0b",
                   $time, out_chan.frame_bytes, out_chan.frame_ok);
          error_count++;
        end else begin
          want = pending_lengths.pop_front();
          if (want.frame_ok) good_frame_count++;
          if (out_chan.frame_bytes !== want.frame_bytes) begin
            $display("%0t: header %h frame_bytes expected %0d actual %0d",
                     $time, want.hdr, want.frame_bytes, out_chan.frame_bytes);
            error_count++;
          end
          if (out_chan.frame_ok !== want.frame_ok) begin
            $display("%0t: header %h frame_ok expected %0b actual %0b",
                     $time, want.hdr, want.frame_ok, out_chan.frame_ok);
            error_count++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        header_count++;
        pending_lengths.push_back(calc_frame_length(in_chan.header_word));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.header_word = '0;
    out_chan.ready = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Each test ends with the sender paused until the pipeline drains.
    test_directed();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();

    // Catch any stray result behind the last one.
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Checked %0d header transactions against %0d results, %0d with a valid length,",
             header_count, result_count, good_frame_count);
    $display("under steady flow, sender gaps, receiver stalls and both; %0d mismatches.",
             error_count);
    if (error_count == 0 && pending_lengths.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
